/* rtl/core/nps_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// nps_pkg
// shared types, constants and helpers of the nearest palette color search unit
// ----------------------------------------------------------------------------
package nps_pkg;

    localparam int unsigned INDEX_W = 8;
    localparam int unsigned COLOR_W = 15;
    localparam int unsigned CHAN_W  = 8;
    localparam int unsigned FIELD_W = 5;
    localparam int unsigned SQ_W    = 16;
    localparam int unsigned DIST_W  = 18;

    localparam logic              KIND_LOAD  = 1'b0;
    localparam logic              KIND_QUERY = 1'b1;
    localparam logic [DIST_W-1:0] DIST_MAX   = '1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_FINISH
    } t_scan_state;

    // one queued request: a palette write or an expanded query color
    typedef struct packed {
        logic               is_query;
        logic [INDEX_W-1:0] index;
        logic [CHAN_W-1:0]  red;
        logic [CHAN_W-1:0]  green;
        logic [CHAN_W-1:0]  blue;
    } t_req;

    function automatic logic [CHAN_W-1:0] expand_channel(input logic [FIELD_W-1:0] field);
        return {field, 3'b100};
    endfunction

endpackage
`default_nettype wire

/* rtl/core/nps_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// nps_front
// accepts input requests, drops out-of-range loads, expands query colors
// ----------------------------------------------------------------------------
module nps_front
    import nps_pkg::*;
#(
    parameter int unsigned PALETTE_ENTRIES = 256
) (
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire logic               i_kind,
    input  wire logic [INDEX_W-1:0] i_entry_index,
    input  wire logic [CHAN_W-1:0]  i_red_value,
    input  wire logic [CHAN_W-1:0]  i_green_value,
    input  wire logic [CHAN_W-1:0]  i_blue_value,
    input  wire logic [COLOR_W-1:0] i_color_word,
    input  wire logic               i_q_full,
    output logic                    o_q_push,
    output t_req                    o_q_data
);

    logic in_range;
    logic is_query;

    assign is_query = (i_kind == KIND_QUERY);
    assign in_range = ({1'b0, i_entry_index} < (INDEX_W + 1)'(PALETTE_ENTRIES));
    assign o_ready  = !i_q_full;
    assign o_q_push = i_valid && !i_q_full && (is_query || in_range);

    always_comb begin
        o_q_data.is_query = is_query;
        o_q_data.index    = i_entry_index;
        if (is_query) begin
            o_q_data.red   = expand_channel(i_color_word[4:0]);
            o_q_data.green = expand_channel(i_color_word[9:5]);
            o_q_data.blue  = expand_channel(i_color_word[14:10]);
        end else begin
            o_q_data.red   = i_red_value;
            o_q_data.green = i_green_value;
            o_q_data.blue  = i_blue_value;
        end
    end

endmodule
`default_nettype wire

/* rtl/core/nps_fifo.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// nps_fifo
// two-entry request queue between the front and the back
// ----------------------------------------------------------------------------
module nps_fifo
    import nps_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_req i_data,
    output logic      o_full,
    input  wire logic i_pop,
    output logic      o_empty,
    output t_req      o_data
);

    t_req       r_slot [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;
    logic       do_push;
    logic       do_pop;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_slot[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (do_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            unique case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule
`default_nettype wire

/* rtl/core/nps_back.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// nps_back
// palette store and pipelined scan that finds the nearest entry
// ----------------------------------------------------------------------------
module nps_back
    import nps_pkg::*;
#(
    parameter int unsigned PALETTE_ENTRIES = 256
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_q_empty,
    input  wire t_req               i_q_data,
    output logic                    o_q_pop,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output logic [INDEX_W-1:0]      o_nearest_index,
    output logic [DIST_W-1:0]       o_best_distance
);

    localparam int unsigned IDXW = $clog2(PALETTE_ENTRIES);
    localparam logic [IDXW-1:0] LAST_ADDR = IDXW'(PALETTE_ENTRIES - 1);

    t_scan_state r_state;
    t_scan_state n_state;

    logic [3*CHAN_W-1:0]  r_mem [PALETTE_ENTRIES];
    logic [PALETTE_ENTRIES-1:0] r_vld;

    logic [CHAN_W-1:0] r_q_red;
    logic [CHAN_W-1:0] r_q_green;
    logic [CHAN_W-1:0] r_q_blue;
    logic [IDXW-1:0]   r_addr;

    logic [3*CHAN_W-1:0] r_rd_data;
    logic                r_rd_vld;
    logic                r_s1_go;
    logic                r_s1_last;
    logic [IDXW-1:0]     r_s1_idx;

    logic [SQ_W-1:0]     r_sq_r;
    logic [SQ_W-1:0]     r_sq_g;
    logic [SQ_W-1:0]     r_sq_b;
    logic                r_s2_go;
    logic                r_s2_last;
    logic [IDXW-1:0]     r_s2_idx;

    logic [DIST_W-1:0]   r_best_d;
    logic [IDXW-1:0]     r_best_idx;
    logic                r_done;

    logic                r_out_valid;
    logic [INDEX_W-1:0]  r_out_idx;
    logic [DIST_W-1:0]   r_out_dist;

    logic pop;
    logic wr_en;
    logic start;
    logic issue;
    logic last;
    logic out_load;
    logic out_free;

    logic [CHAN_W-1:0] pal_r;
    logic [CHAN_W-1:0] pal_g;
    logic [CHAN_W-1:0] pal_b;
    logic [CHAN_W-1:0] dif_r;
    logic [CHAN_W-1:0] dif_g;
    logic [CHAN_W-1:0] dif_b;
    logic [DIST_W-1:0] cand_d;

    assign out_free = !r_out_valid || i_ready;
    assign last     = (r_addr == LAST_ADDR);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (!i_q_empty && i_q_data.is_query) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (r_done) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        pop      = 1'b0;
        wr_en    = 1'b0;
        start    = 1'b0;
        issue    = 1'b0;
        out_load = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                pop   = !i_q_empty;
                wr_en = !i_q_empty && !i_q_data.is_query;
                start = !i_q_empty && i_q_data.is_query;
            end
            S_SCAN:   issue    = 1'b1;
            S_DRAIN:  issue    = 1'b0;
            S_FINISH: out_load = out_free;
            default:  issue    = 1'b0;
        endcase
    end

    assign o_q_pop = pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // palette store
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[i_q_data.index[IDXW-1:0]] <= {i_q_data.red, i_q_data.green, i_q_data.blue};
        end
        r_rd_data <= r_mem[r_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (wr_en) begin
            r_vld[i_q_data.index[IDXW-1:0]] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_vld <= r_vld[r_addr];
        r_s1_idx <= r_addr;
        if (start) begin
            r_q_red   <= i_q_data.red;
            r_q_green <= i_q_data.green;
            r_q_blue  <= i_q_data.blue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr <= '0;
        end else if (start) begin
            r_addr <= '0;
        end else if (issue && !last) begin
            r_addr <= r_addr + 1'b1;
        end
    end

    // stage 2: squared channel differences
    assign pal_r = r_rd_vld ? r_rd_data[3*CHAN_W-1:2*CHAN_W] : '0;
    assign pal_g = r_rd_vld ? r_rd_data[2*CHAN_W-1:CHAN_W]   : '0;
    assign pal_b = r_rd_vld ? r_rd_data[CHAN_W-1:0]          : '0;
    assign dif_r = (r_q_red   >= pal_r) ? (r_q_red   - pal_r) : (pal_r - r_q_red);
    assign dif_g = (r_q_green >= pal_g) ? (r_q_green - pal_g) : (pal_g - r_q_green);
    assign dif_b = (r_q_blue  >= pal_b) ? (r_q_blue  - pal_b) : (pal_b - r_q_blue);

    always_ff @(posedge i_clk) begin
        r_sq_r   <= SQ_W'(dif_r) * SQ_W'(dif_r);
        r_sq_g   <= SQ_W'(dif_g) * SQ_W'(dif_g);
        r_sq_b   <= SQ_W'(dif_b) * SQ_W'(dif_b);
        r_s2_idx <= r_s1_idx;
    end

    // stage 3: sum and keep the first minimum
    assign cand_d = DIST_W'(r_sq_r) + DIST_W'(r_sq_g) + DIST_W'(r_sq_b);

    always_ff @(posedge i_clk) begin
        if (start) begin
            r_best_d   <= DIST_MAX;
            r_best_idx <= '0;
        end else if (r_s2_go && (cand_d < r_best_d)) begin
            r_best_d   <= cand_d;
            r_best_idx <= r_s2_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_go   <= 1'b0;
            r_s1_last <= 1'b0;
            r_s2_go   <= 1'b0;
            r_s2_last <= 1'b0;
            r_done    <= 1'b0;
        end else begin
            r_s1_go   <= issue;
            r_s1_last <= issue && last;
            r_s2_go   <= r_s1_go;
            r_s2_last <= r_s1_last;
            r_done    <= r_s2_go && r_s2_last;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_idx  <= INDEX_W'(r_best_idx);
            r_out_dist <= r_best_d;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_nearest_index = r_out_idx;
    assign o_best_distance = r_out_dist;

endmodule
`default_nettype wire

/* rtl/core/nearest_palette_color_search_unit.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// nearest_palette_color_search_unit
// palette loads and nearest color queries over a decoupled front and back
// ----------------------------------------------------------------------------
// queries: the back scans every palette entry for each query and starts no new
//   query until the previous result is in the result register; one palette entry
//   is read per cycle from the store; loads are written only while the back is idle
// reset: synchronous, clears the queue, the result valid flag and every palette
//   entry valid bit at once; unwritten entries read as zero
// ----------------------------------------------------------------------------
module nearest_palette_color_search_unit
    import nps_pkg::*;
#(
    parameter int unsigned PALETTE_ENTRIES = 256
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire logic               i_kind,
    input  wire logic [INDEX_W-1:0] i_entry_index,
    input  wire logic [CHAN_W-1:0]  i_red_value,
    input  wire logic [CHAN_W-1:0]  i_green_value,
    input  wire logic [CHAN_W-1:0]  i_blue_value,
    input  wire logic [COLOR_W-1:0] i_color_word,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output logic [INDEX_W-1:0]      o_nearest_index,
    output logic [DIST_W-1:0]       o_best_distance
);

    logic q_full;
    logic q_push;
    logic q_empty;
    logic q_pop;
    t_req q_wr_data;
    t_req q_rd_data;

    nps_front #(
        .PALETTE_ENTRIES(PALETTE_ENTRIES)
    ) u_front (
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_kind        (i_kind),
        .i_entry_index (i_entry_index),
        .i_red_value   (i_red_value),
        .i_green_value (i_green_value),
        .i_blue_value  (i_blue_value),
        .i_color_word  (i_color_word),
        .i_q_full      (q_full),
        .o_q_push      (q_push),
        .o_q_data      (q_wr_data)
    );

    nps_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wr_data),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_data  (q_rd_data)
    );

    nps_back #(
        .PALETTE_ENTRIES(PALETTE_ENTRIES)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_empty       (q_empty),
        .i_q_data        (q_rd_data),
        .o_q_pop         (q_pop),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_nearest_index (o_nearest_index),
        .o_best_distance (o_best_distance)
    );

endmodule
`default_nettype wire

/* tb/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// checks palette loads and nearest color queries against a behavioral palette
// search, with random gaps on the request side and random stalls on results
// ----------------------------------------------------------------------------
module tb
    import nps_pkg::*;
;

    localparam int unsigned ENTRY_COUNT  = 256;
    localparam int unsigned DRAIN_CYCLES = 300;
    localparam int unsigned RANDOM_ITEMS = 1830;

    typedef struct packed {
        logic [INDEX_W-1:0] index;
        logic [DIST_W-1:0]  distance;
    } t_answer;

    class nearest_color_book;
        bit [CHAN_W-1:0] pal_red   [ENTRY_COUNT];
        bit [CHAN_W-1:0] pal_green [ENTRY_COUNT];
        bit [CHAN_W-1:0] pal_blue  [ENTRY_COUNT];
        t_answer         pending_answers[$];
        int              mismatch_count;

        function int widen(input logic [FIELD_W-1:0] field);
            return (int'(field) << 3) + 4;
        endfunction

        function t_answer find_nearest(input logic [COLOR_W-1:0] word);
            int      red_x;
            int      green_x;
            int      blue_x;
            int      cur_d;
            int      best;
            t_answer pick;
            red_x      = widen(word[4:0]);
            green_x    = widen(word[9:5]);
            blue_x     = widen(word[14:10]);
            best       = 32'h7fff_ffff;
            pick.index = '0;
            for (int v = 0; v < ENTRY_COUNT; v++) begin
                cur_d = (red_x - int'(pal_red[v])) * (red_x - int'(pal_red[v]))
                      + (green_x - int'(pal_green[v])) * (green_x - int'(pal_green[v]))
                      + (blue_x - int'(pal_blue[v])) * (blue_x - int'(pal_blue[v]));
                if (cur_d < best) begin
                    best       = cur_d;
                    pick.index = v[INDEX_W-1:0];
                end
            end
            pick.distance = best[DIST_W-1:0];
            return pick;
        endfunction

        function void note_request(input logic kind, input logic [INDEX_W-1:0] idx,
                                   input logic [CHAN_W-1:0] red, input logic [CHAN_W-1:0] green,
                                   input logic [CHAN_W-1:0] blue,
                                   input logic [COLOR_W-1:0] word);
            if (kind == KIND_LOAD) begin
                pal_red[idx]   = red;
                pal_green[idx] = green;
                pal_blue[idx]  = blue;
            end else begin
                pending_answers.push_back(find_nearest(word));
            end
        endfunction

        function void check_answer(input logic [INDEX_W-1:0] idx,
                                   input logic [DIST_W-1:0] got_d);
            t_answer want;
            if (pending_answers.size() == 0) begin
                $error("result with no query waiting: nearest_index %0d best_distance %0d",
                       idx, got_d);
                mismatch_count++;
                return;
            end
            want = pending_answers.pop_front();
            if (idx !== want.index) begin
                $error("nearest_index: expected %0d, actual %0d", want.index, idx);
                mismatch_count++;
            end
            if (got_d !== want.distance) begin
                $error("best_distance: expected %0d, actual %0d", want.distance, got_d);
                mismatch_count++;
            end
        endfunction
    endclass

    logic               i_clk         = 1'b0;
    logic               i_rst_n       = 1'b0;
    logic               i_valid       = 1'b0;
    logic               o_ready;
    logic               i_kind        = KIND_LOAD;
    logic [INDEX_W-1:0] i_entry_index = '0;
    logic [CHAN_W-1:0]  i_red_value   = '0;
    logic [CHAN_W-1:0]  i_green_value = '0;
    logic [CHAN_W-1:0]  i_blue_value  = '0;
    logic [COLOR_W-1:0] i_color_word  = '0;
    logic               o_valid;
    logic               i_ready       = 1'b0;
    logic [INDEX_W-1:0] o_nearest_index;
    logic [DIST_W-1:0]  o_best_distance;

    nearest_color_book book = new();
    bit                sender_calm;
    bit                receiver_calm;
    bit [23:0]         tie_colors [8];

    nearest_palette_color_search_unit i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_kind          (i_kind),
        .i_entry_index   (i_entry_index),
        .i_red_value     (i_red_value),
        .i_green_value   (i_green_value),
        .i_blue_value    (i_blue_value),
        .i_color_word    (i_color_word),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_nearest_index (o_nearest_index),
        .o_best_distance (o_best_distance)
    );

    always #5 i_clk = ~i_clk;

    // calm stretches give runs with no idling at all
    function automatic int draw_pause(ref bit calm);
        if ($urandom_range(0, 31) == 0) begin
            calm = ~calm;
        end
        return calm ? 0 : $urandom_range(0, 14);
    endfunction

    // called and returns at a falling edge
    task automatic send_request(input logic kind, input logic [INDEX_W-1:0] idx,
                                input logic [CHAN_W-1:0] red, input logic [CHAN_W-1:0] green,
                                input logic [CHAN_W-1:0] blue,
                                input logic [COLOR_W-1:0] word);
        int gap;
        gap = draw_pause(sender_calm);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid       <= 1'b1;
        i_kind        <= kind;
        i_entry_index <= idx;
        i_red_value   <= red;
        i_green_value <= green;
        i_blue_value  <= blue;
        i_color_word  <= word;
        do @(posedge i_clk); while (o_ready !== 1'b1);
        book.note_request(kind, idx, red, green, blue, word);
        @(negedge i_clk);
    endtask

    task automatic send_load(input logic [INDEX_W-1:0] idx, input logic [CHAN_W-1:0] red,
                             input logic [CHAN_W-1:0] green, input logic [CHAN_W-1:0] blue);
        send_request(KIND_LOAD, idx, red, green, blue, COLOR_W'($urandom));
    endtask

    task automatic send_query(input logic [COLOR_W-1:0] word);
        send_request(KIND_QUERY, INDEX_W'($urandom), CHAN_W'($urandom), CHAN_W'($urandom),
                     CHAN_W'($urandom), word);
    endtask

    // picks a load color: random, on the query grid, near the grid, or from a shared set
    task automatic send_random_load();
        logic [INDEX_W-1:0] idx;
        logic [23:0]        rgb;
        idx = ($urandom_range(0, 3) == 0) ? INDEX_W'($urandom_range(0, 15))
                                          : INDEX_W'($urandom);
        case ($urandom_range(0, 3))
            0: rgb = 24'($urandom);
            1: rgb = {FIELD_W'($urandom), 3'b100, FIELD_W'($urandom), 3'b100,
                      FIELD_W'($urandom), 3'b100};
            2: rgb = {FIELD_W'($urandom), 3'($urandom), FIELD_W'($urandom), 3'($urandom),
                      FIELD_W'($urandom), 3'($urandom)};
            default: rgb = tie_colors[$urandom_range(0, 7)];
        endcase
        send_load(idx, rgb[23:16], rgb[15:8], rgb[7:0]);
    endtask

    initial begin
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            int stall;
            stall = draw_pause(receiver_calm);
            if (stall > 0) begin
                i_ready <= 1'b0;
                // sometimes hold off until a result is actually waiting
                if ($urandom_range(0, 1) == 1) begin
                    do @(posedge i_clk); while (o_valid !== 1'b1);
                    @(negedge i_clk);
                end
                repeat (stall) @(negedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (o_valid !== 1'b1);
            book.check_answer(o_nearest_index, o_best_distance);
            @(negedge i_clk);
        end
    end

    initial begin
        foreach (tie_colors[k]) begin
            tie_colors[k] = 24'($urandom);
        end
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // cleared palette: every entry ties, index 0 wins
        send_query('0);
        send_query('1);
        send_query(COLOR_W'($urandom));
        send_load(8'd0, 8'hff, 8'hff, 8'hff);
        send_load(8'd255, 8'h00, 8'h00, 8'h00);
        send_query('0);
        send_load(8'd255, 8'd252, 8'd252, 8'd252);
        send_query('1);
        send_load(8'd10, 8'd4, 8'd4, 8'd4);
        send_load(8'd200, 8'd4, 8'd4, 8'd4);
        send_query('0);
        send_load(8'd128, 8'd44, 8'd140, 8'd244);
        send_query({5'd30, 5'd17, 5'd5});
        send_query(15'h001f);
        send_query(15'h03e0);
        send_query(15'h7c00);
        send_load(8'd64, 8'hff, 8'h00, 8'h80);
        send_load(8'd65, 8'h00, 8'hff, 8'h7f);
        send_query(15'h2aaa);
        send_query(15'h5555);

        repeat (RANDOM_ITEMS) begin
            if ($urandom_range(0, 99) < 55) begin
                send_random_load();
            end else begin
                send_query(COLOR_W'($urandom));
            end
        end
        i_valid <= 1'b0;

        while (book.pending_answers.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (book.mismatch_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin
        #30_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

/* sim.f */
rtl/core/nps_pkg.sv
rtl/core/nps_front.sv
rtl/core/nps_fifo.sv
rtl/core/nps_back.sv
rtl/core/nearest_palette_color_search_unit.sv
tb/tb.sv
